>>> hdl/dof_compaction_remap_assert.svh
// Assertion macros for the checker file of the index remap block.
`ifndef DOF_COMPACTION_REMAP_ASSERT_SVH
`define DOF_COMPACTION_REMAP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DCR_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DCR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/dcr_pkg.sv
// Types and constants of the degree-of-freedom compaction and remap block.
package dcr_pkg;

    localparam int unsigned IDX_W     = 12;
    localparam int unsigned CNT_W     = 13;
    localparam int unsigned ADDR_W    = 24;
    localparam int unsigned DATA_W    = 64;
    localparam int unsigned PROD_W    = IDX_W + CNT_W;
    localparam int unsigned S_TDATA_W = 88;   // index, col_index, value
    localparam int unsigned M_TDATA_W = 112;  // dest_row, dest_col, dest_address, data_out

    // Entries reachable through a 12-bit index, and the largest 13-bit count.
    localparam int unsigned ROW_SPAN  = 4096;
    localparam int unsigned COUNT_MAX = 8191;

    localparam logic [CNT_W-1:0] DOF_COUNT_RST = 13'd4096;

    localparam logic [0:0] REG_DOF_COUNT  = 1'b0;
    localparam logic [0:0] REG_REMAP_MODE = 1'b1;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_MARK  = 2'd1,
        KIND_BUILD = 2'd2,
        KIND_REMAP = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MARK,
        ST_BUILD,
        ST_REMAP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             constrained;
        logic [IDX_W-1:0] number;
    } entry_t;

endpackage

>>> hdl/dcr_table.sv
// Index table memory: one write port, two registered read ports.
module dcr_table #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW    = 12
) (
    input  logic            aclk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  dcr_pkg::entry_t wdata,
    input  logic [AW-1:0]   raddr_a,
    input  logic [AW-1:0]   raddr_b,
    output dcr_pkg::entry_t rdata_a,
    output dcr_pkg::entry_t rdata_b
);

    dcr_pkg::entry_t mem [DEPTH];
    dcr_pkg::entry_t rdata_a_reg;
    dcr_pkg::entry_t rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

>>> hdl/dof_compaction_remap.sv
// Degree-of-freedom compaction table with vector and dense matrix element remap.
//
// Kind in s_tuser selects the transaction: clear table, mark an index constrained, build
// the compacted numbering, or remap an element. The table lives in one memory of
// min(MAX_DOFS, 4096) entries with two registered read ports. After reset the block runs
// a clearing pass over all min(MAX_DOFS, 4096) entries with s_tready low; configuration
// writes are taken during it. A clear transaction runs the same pass, and a mark reads
// the entry at accept and writes it back flagged (not when the index is out of range).
// A build walks n = min(dof_count, MAX_DOFS) entries and writes compacted numbers to the
// unconstrained ones one entry behind the read. A remap goes through accept with table
// read, keep decision and multiply, then output load, skipped for a dropped element;
// the result goes into an output register, so the next transaction is accepted while
// m_tvalid waits for m_tready; output load waits only while an earlier result is held.
module dof_compaction_remap #(
    parameter int unsigned MAX_DOFS = 4096
) (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         cfg_wr_en,
    input  logic [0:0]   cfg_index,
    input  logic [12:0]  cfg_wdata,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [87:0]  s_tdata,   // index[11:0], col_index[23:12], value[87:24]
    input  logic [1:0]   s_tuser,   // kind[1:0]

    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata    // dest_row[11:0], dest_col[23:12],
                                    // dest_address[47:24], data_out[111:48]
);

    localparam int unsigned DEPTH = (MAX_DOFS > dcr_pkg::ROW_SPAN) ? dcr_pkg::ROW_SPAN
                                                                    : MAX_DOFS;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned NCAP  = (MAX_DOFS > dcr_pkg::COUNT_MAX) ? dcr_pkg::COUNT_MAX
                                                                     : MAX_DOFS;
    localparam logic [dcr_pkg::CNT_W-1:0] ACT_CAP  = dcr_pkg::CNT_W'(NCAP);
    localparam logic [dcr_pkg::CNT_W-1:0] DEPTH_C  = dcr_pkg::CNT_W'(DEPTH);
    localparam logic [dcr_pkg::CNT_W-1:0] LAST_CLR = dcr_pkg::CNT_W'(DEPTH - 1);

    // Input fields
    logic [dcr_pkg::IDX_W-1:0]  s_index;
    logic [dcr_pkg::IDX_W-1:0]  s_col;
    logic [dcr_pkg::DATA_W-1:0] s_value;
    dcr_pkg::kind_t             s_kind;
    logic                       s_accept;

    assign s_index  = s_tdata[11:0];
    assign s_col    = s_tdata[23:12];
    assign s_value  = s_tdata[87:24];
    assign s_kind   = dcr_pkg::kind_t'(s_tuser);
    assign s_accept = s_tvalid & s_tready;

    // Configuration
    logic [dcr_pkg::CNT_W-1:0] dof_count_reg;
    logic                      remap_mode_reg;
    logic [dcr_pkg::CNT_W-1:0] act_cnt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dof_count_reg  <= dcr_pkg::DOF_COUNT_RST;
            remap_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                dcr_pkg::REG_DOF_COUNT:  dof_count_reg  <= cfg_wdata;
                dcr_pkg::REG_REMAP_MODE: remap_mode_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign act_cnt = (dof_count_reg > ACT_CAP) ? ACT_CAP : dof_count_reg;

    // Control state
    dcr_pkg::state_t           state_reg, state_next;
    logic [dcr_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [dcr_pkg::CNT_W-1:0] num_reg, num_next;
    logic [dcr_pkg::CNT_W-1:0] pidx_reg, pidx_next;
    logic                      pv_reg, pv_next;
    logic [dcr_pkg::CNT_W-1:0] kept_reg, kept_next;
    logic                      m_valid_reg, m_valid_next;

    // Payload
    logic [dcr_pkg::IDX_W-1:0]   row_reg;
    logic [dcr_pkg::IDX_W-1:0]   col_reg;
    logic [dcr_pkg::DATA_W-1:0]  value_reg;
    logic [dcr_pkg::IDX_W-1:0]   drow_reg;
    logic [dcr_pkg::IDX_W-1:0]   dcol_reg;
    logic [dcr_pkg::PROD_W-1:0]  prod_reg;
    logic [dcr_pkg::M_TDATA_W-1:0] m_data_reg;

    // Table ports
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    dcr_pkg::entry_t mem_wdata;
    logic [AW-1:0]   mem_raddr_a;
    logic [AW-1:0]   mem_raddr_b;
    dcr_pkg::entry_t mem_rdata_a;
    dcr_pkg::entry_t mem_rdata_b;

    logic                      remap_keep;
    logic [dcr_pkg::IDX_W-1:0] remap_dcol;
    logic                      in_mem;
    logic                      out_load;
    logic [dcr_pkg::PROD_W-1:0] addr_sum;

    dcr_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .aclk    (aclk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    // Remap decision from the table read issued at accept
    always_comb begin
        remap_keep = ({1'b0, row_reg} < act_cnt) && !mem_rdata_a.constrained;
        if (remap_mode_reg) begin
            remap_keep = remap_keep && ({1'b0, col_reg} < act_cnt)
                         && !mem_rdata_b.constrained;
            remap_dcol = mem_rdata_b.number;
        end else begin
            remap_dcol = '0;
        end
    end

    assign in_mem = (pidx_reg < DEPTH_C);

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        num_next     = num_reg;
        pidx_next    = pidx_reg;
        pv_next      = pv_reg;
        kept_next    = kept_reg;
        s_tready     = 1'b0;
        out_load     = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = cnt_reg[AW-1:0];
        mem_wdata    = '0;
        mem_raddr_a  = s_index[AW-1:0];
        mem_raddr_b  = s_col[AW-1:0];

        case (state_reg)
            dcr_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[AW-1:0];
                if (cnt_reg == LAST_CLR) begin
                    cnt_next   = '0;
                    state_next = dcr_pkg::ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            dcr_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (s_kind)
                        dcr_pkg::KIND_CLEAR: begin
                            cnt_next   = '0;
                            state_next = dcr_pkg::ST_CLEAR;
                        end
                        dcr_pkg::KIND_MARK: begin
                            if ({1'b0, s_index} < act_cnt) begin
                                state_next = dcr_pkg::ST_MARK;
                            end
                        end
                        dcr_pkg::KIND_BUILD: begin
                            cnt_next   = '0;
                            num_next   = '0;
                            pv_next    = 1'b0;
                            state_next = dcr_pkg::ST_BUILD;
                        end
                        dcr_pkg::KIND_REMAP: begin
                            state_next = dcr_pkg::ST_REMAP;
                        end
                        default: ;
                    endcase
                end
            end

            dcr_pkg::ST_MARK: begin
                // keep the stale number, set the flag
                mem_we                = 1'b1;
                mem_waddr             = row_reg[AW-1:0];
                mem_wdata.constrained = 1'b1;
                mem_wdata.number      = mem_rdata_a.number;
                state_next            = dcr_pkg::ST_IDLE;
            end

            dcr_pkg::ST_BUILD: begin
                // read stage at cnt, write stage one entry behind
                mem_raddr_a = cnt_reg[AW-1:0];
                if (cnt_reg < act_cnt) begin
                    pv_next   = 1'b1;
                    pidx_next = cnt_reg;
                    cnt_next  = cnt_reg + 1'b1;
                end else begin
                    pv_next = 1'b0;
                end
                if (pv_reg) begin
                    // entries past the memory can never be marked
                    if (!(in_mem && mem_rdata_a.constrained)) begin
                        num_next = num_reg + 1'b1;
                        if (in_mem) begin
                            mem_we           = 1'b1;
                            mem_waddr        = pidx_reg[AW-1:0];
                            mem_wdata.number = num_reg[dcr_pkg::IDX_W-1:0];
                        end
                    end
                end else if (cnt_reg >= act_cnt) begin
                    kept_next  = num_reg;
                    state_next = dcr_pkg::ST_IDLE;
                end
            end

            dcr_pkg::ST_REMAP: begin
                if (remap_keep) begin
                    state_next = dcr_pkg::ST_OUT;
                end else begin
                    state_next = dcr_pkg::ST_IDLE;
                end
            end

            dcr_pkg::ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = dcr_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = dcr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dcr_pkg::ST_CLEAR;
            cnt_reg     <= '0;
            num_reg     <= '0;
            pidx_reg    <= '0;
            pv_reg      <= 1'b0;
            kept_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            num_reg     <= num_next;
            pidx_reg    <= pidx_next;
            pv_reg      <= pv_next;
            kept_reg    <= kept_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign addr_sum = prod_reg + {{(dcr_pkg::PROD_W - dcr_pkg::IDX_W){1'b0}}, drow_reg};

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            row_reg   <= s_index;
            col_reg   <= s_col;
            value_reg <= s_value;
        end
        if (state_reg == dcr_pkg::ST_REMAP) begin
            drow_reg <= mem_rdata_a.number;
            dcol_reg <= remap_dcol;
            prod_reg <= dcr_pkg::PROD_W'(remap_dcol) * dcr_pkg::PROD_W'(kept_reg);
        end
        if (out_load) begin
            m_data_reg <= {value_reg, addr_sum[dcr_pkg::ADDR_W-1:0], dcol_reg, drow_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> hdl/dcr_checker.sv
// Port-level checker for the index remap block, bound to the top level.
`include "dof_compaction_remap_assert.svh"

module dcr_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [1:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata
);

    `DCR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `DCR_ASSERT_NEXT(a_no_result_rise, aclk, aresetn, s_tvalid && s_tready && (s_tuser != dcr_pkg::KIND_REMAP), !$rose(m_tvalid), "result after a non-element transaction")
    `DCR_ASSERT_NEXT(a_busy_after, aclk, aresetn, s_tvalid && s_tready && (s_tuser != dcr_pkg::KIND_MARK), !s_tready, "ready right after a multi-cycle transaction")
    `DCR_ASSERT_IMPL(a_col0_addr, aclk, aresetn, m_tvalid && (m_tdata[23:12] == 12'd0), m_tdata[47:24] == {12'd0, m_tdata[11:0]}, "address differs from row in column zero")

endmodule

bind dof_compaction_remap dcr_checker u_dcr_checker (.*);
